[rtl/core/pil_pkg.sv]
// Shared types and constants for the profile interpolation lookup unit.
package pil_pkg;

	localparam int unsigned DistW  = 32;
	localparam int unsigned LevelW = 16;
	localparam int unsigned FracW  = 16;

	// Register index of the breakpoint count on the configuration port.
	localparam logic [0:0] REG_POINTS_IN_USE = 1'b0;

	typedef enum logic {
		MODE_LOAD  = 1'b0,
		MODE_QUERY = 1'b1
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_READ,
		ST_PAIR,
		ST_DIV,
		ST_BLEND,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             mode;
		logic [11:0]      index;
		logic [DistW-1:0] distance;
		logic [LevelW-1:0] level;
		logic [DistW-1:0] query;
	} item_t;

	typedef struct packed {
		logic [LevelW-1:0] level;
		logic              beyond;
	} result_t;

endpackage

[rtl/core/pil_front.sv]
// Input stage: registers accepted items into a two-entry queue toward the engine.
module pil_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  pil_pkg::item_t  in_item,
	output logic            q_valid,
	input  logic            q_ready,
	output pil_pkg::item_t  q_item
);
	import pil_pkg::*;

	item_t     buf_q [2];
	logic      wp_q, rp_q;
	logic [1:0] cnt_q;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) buf_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (q_valid && q_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
		end
	end
endmodule

[rtl/core/pil_engine.sv]
// Back end: table memory, binary search, serial divider and blend.
module pil_engine #(
	parameter int unsigned TABLE_DEPTH = 256,
	parameter int unsigned IDX_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  pil_pkg::item_t    q_item,
	input  logic [IDX_W:0]    count,
	output logic              res_valid,
	input  logic              res_ready,
	output pil_pkg::result_t  res
);
	import pil_pkg::*;

	localparam int unsigned BlendW = FracW + LevelW + 1;

	logic [DistW-1:0]  bp_mem [TABLE_DEPTH];
	logic [LevelW-1:0] lv_mem [TABLE_DEPTH];
	logic [DistW-1:0]  bp_rd_q;
	logic [LevelW-1:0] lv_rd_q;
	logic [IDX_W-1:0]  raddr;

	state_t state_q, state_d;
	logic [DistW-1:0] query_q;
	logic [IDX_W:0]   lo_q, cnt_q, n_q;
	logic [DistW-1:0] d0_q, den_q, rem_q;
	logic [LevelW-1:0] v0_q, v1_q;
	logic             probe_q, pair_q;
	logic [FracW:0]   frac_q;
	logic [3:0]       dstep_q;
	logic             ovr_q, zero_q;
	result_t          out_q, res_q;
	logic             rv_q;

	logic [IDX_W:0]    half, mid;
	logic [DistW:0]    trial, diff;
	logic [FracW:0]    frac_eff, w0;
	logic [BlendW-1:0] blend;
	logic              is_load, take, out_free;

	assign half = cnt_q >> 1;
	assign mid  = lo_q + half;

	// Read port: search probe, then the lower and the upper neighbor.
	always_comb begin
		raddr = mid[IDX_W-1:0];
		if (state_q == ST_READ) raddr = (lo_q == '0) ? '0 : IDX_W'(lo_q - 1'b1);
		else if (state_q == ST_PAIR) raddr = lo_q[IDX_W-1:0];
	end

	assign is_load  = (q_item.mode == MODE_LOAD);
	assign take     = q_valid && q_ready;
	assign q_ready  = (state_q == ST_IDLE);
	assign out_free = !rv_q || res_ready;

	always_ff @(posedge clk) begin
		if (take && is_load && 32'(q_item.index) < TABLE_DEPTH) begin
			bp_mem[q_item.index[IDX_W-1:0]] <= q_item.distance;
			lv_mem[q_item.index[IDX_W-1:0]] <= q_item.level;
		end
		bp_rd_q <= bp_mem[raddr];
		lv_rd_q <= lv_mem[raddr];
	end

	// Restoring division step and the clamped fraction used by the blend.
	assign trial = {rem_q, 1'b0};
	assign diff  = trial - {1'b0, den_q};

	always_comb begin
		frac_eff = frac_q;
		if (zero_q) frac_eff = '0;
		else if (ovr_q) frac_eff = {1'b1, {FracW{1'b0}}};
	end

	assign w0 = {1'b1, {FracW{1'b0}}} - frac_eff;
	assign blend = BlendW'(w0) * BlendW'(v0_q) + BlendW'(frac_eff) * BlendW'(v1_q)
		+ (BlendW'(1) << (FracW - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (take && !is_load) state_d = ST_SEARCH;
			ST_SEARCH: if (cnt_q == '0) state_d = ST_READ;
			ST_READ:   state_d = ST_PAIR;
			ST_PAIR:   if (pair_q) state_d = ST_DIV;
			ST_DIV:    if (dstep_q == 4'd0) state_d = ST_BLEND;
			ST_BLEND:  state_d = ST_DONE;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rv_q <= 1'b0;
			probe_q <= 1'b0;
			pair_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) rv_q <= 1'b1;
			else if (res_ready) rv_q <= 1'b0;
			// A probe puts its address out, then compares on the registered read data.
			probe_q <= (state_q == ST_SEARCH) && !probe_q && (cnt_q != '0);
			pair_q <= (state_q == ST_PAIR);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				query_q <= q_item.query;
				lo_q <= '0;
				cnt_q <= count;
				n_q <= count;
			end
			ST_SEARCH: if (probe_q) begin
				if (bp_rd_q < query_q) begin
					lo_q <= mid + 1'b1;
					cnt_q <= cnt_q - half - 1'b1;
				end else begin
					cnt_q <= half;
				end
			end
			ST_READ: ;
			ST_PAIR: if (!pair_q) begin
				d0_q <= bp_rd_q;
				v0_q <= lv_rd_q;
			end else begin
				v1_q <= lv_rd_q;
				den_q <= bp_rd_q - d0_q;
				zero_q <= (query_q <= d0_q);
				// Past the upper breakpoint, or a flat or descending segment.
				ovr_q <= (bp_rd_q <= d0_q) || (query_q >= bp_rd_q);
				rem_q <= query_q - d0_q;
				frac_q <= '0;
				dstep_q <= 4'(FracW - 1);
			end
			ST_DIV: begin
				if (trial >= {1'b0, den_q}) begin
					rem_q <= diff[DistW-1:0];
					frac_q <= {frac_q[FracW-1:0], 1'b1};
				end else begin
					rem_q <= trial[DistW-1:0];
					frac_q <= {frac_q[FracW-1:0], 1'b0};
				end
				dstep_q <= dstep_q - 1'b1;
			end
			ST_BLEND: begin
				if (lo_q >= n_q) out_q <= '{level: '0, beyond: 1'b1};
				else if (lo_q == '0) out_q <= '{level: v0_q, beyond: 1'b0};
				else out_q <= '{level: blend[FracW+LevelW-1:FracW], beyond: 1'b0};
			end
			ST_DONE: if (out_free) res_q <= out_q;
			default: ;
		endcase
	end

	assign res_valid = rv_q;
	assign res = res_q;
endmodule

[rtl/core/profile_interpolation_lookup_unit.sv]
// Top level of the profile interpolation lookup unit.
// Usage: items arrive on the s_axis channel. mode 0 loads one table entry
// (entry_index, entry_distance, entry_level) and gives no transfer out;
// mode 1 queries query_distance and gives one transfer on m_axis with the
// interpolated level and a beyond_table flag.
// A two-entry input queue decouples acceptance from the engine, so the
// sender can keep pushing while the engine works on an earlier query.
// A query passes the queue, is taken by the engine and runs the binary
// search, where each probe goes through the single memory read port:
// 8 or 9 probes with 256 points, 1 or 2 with two points. The engine then
// leaves the search, reads the lower and the upper neighbor, runs 16
// divider steps, blends and registers the output. The engine starts a
// new query once the result sits in the output register; a load is written
// while the engine is idle, and the engine stays ready for the next item.
// Reset clears the queue and the engine state and sets points_in_use to 256;
// the table itself is not cleared and must be written before it is queried.
// When the receiver holds m_axis_tready low, the result is held stable, the
// engine finishes the next query and waits, then the queue fills and
// s_axis_tready drops. points_in_use is written over APB address 0; the user
// must write it only while idle, which the block itself does not enforce.
module profile_interpolation_lookup_unit #(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// bits: entry_index[7:0], entry_distance[39:8], entry_level[55:40], query_distance[87:56]
	input  logic [87:0] s_axis_tdata,
	// bit 0: mode
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// bits: level_out[15:0]
	output logic [15:0] m_axis_tdata,
	// bit 0: beyond_table
	output logic        m_axis_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pil_pkg::*;

	localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic [8:0] points_q;
	logic [IdxW:0] eff;
	item_t in_item, q_item;
	logic q_valid, q_ready;
	result_t res;

	assign pready = 1'b1;
	assign prdata = {23'd0, points_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) points_q <= 9'd256;
		else if (psel && penable && pwrite && paddr == REG_POINTS_IN_USE)
			points_q <= pwdata[8:0];
	end

	// Clamp the breakpoint count into [2, TABLE_DEPTH].
	always_comb begin
		if (32'(points_q) > TABLE_DEPTH) eff = (IdxW+1)'(TABLE_DEPTH);
		else if (points_q < 9'd2) eff = (IdxW+1)'(2);
		else eff = (IdxW+1)'(points_q);
	end

	assign in_item.mode = s_axis_tuser;
	assign in_item.index = 12'(s_axis_tdata[7:0]);
	assign in_item.distance = s_axis_tdata[39:8];
	assign in_item.level = s_axis_tdata[55:40];
	assign in_item.query = s_axis_tdata[87:56];

	pil_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item,
		.q_valid, .q_ready, .q_item
	);

	pil_engine #(.TABLE_DEPTH(TABLE_DEPTH), .IDX_W(IdxW)) u_engine (
		.clk, .arst_n,
		.q_valid, .q_ready, .q_item,
		.count(eff),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
	);

	assign m_axis_tdata = res.level;
	assign m_axis_tuser = res.beyond;
endmodule

[bench/tb.sv]
// Self-checking testbench for the profile interpolation lookup unit.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pil_pkg::*;

	localparam int unsigned DEPTH = 256;
	localparam int unsigned STALL_LIMIT = 20000;
	localparam int unsigned RANDOM_ITEMS = 560;
	localparam int unsigned DRAIN_CYCLES = 60;

	// Result of one query, as seen on the output stream.
	typedef struct packed {
		logic [15:0] level;
		logic        beyond;
	} lookup_t;

	// One row of the directed table; check_now selects a typed-in result.
	typedef struct {
		mode_t       mode;
		logic [7:0]  slot;
		logic [31:0] bp_dist;
		logic [15:0] lvl;
		logic [31:0] query;
		bit          check_now;
		logic [15:0] want_level;
		logic        want_beyond;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// bits: entry_index[7:0], entry_distance[39:8], entry_level[55:40], query_distance[87:56]
	logic [87:0] s_axis_tdata;
	// bit 0: mode
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// bits: level_out[15:0]
	logic [15:0] m_axis_tdata;
	// bit 0: beyond_table
	logic        m_axis_tuser;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [0:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	profile_interpolation_lookup_unit dut (.*);

	// Model copy of the table and the register.
	logic [31:0] model_dist [DEPTH];
	logic [15:0] model_level [DEPTH];
	logic [8:0]  model_points;

	lookup_t     pending_lookups [$];
	int unsigned fail_count;
	int unsigned query_count;
	int unsigned load_count;
	int unsigned result_count;
	int unsigned idle_cycles;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	bit          recv_hold;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Predicts the lookup of one query against the model table.
	function automatic lookup_t predict_lookup(logic [31:0] q);
		int unsigned n, lo, cnt, h, m;
		longint d0, d1, num, den, f, v0, v1;
		lookup_t r;
		n = model_points;
		if (n > DEPTH) n = DEPTH;
		if (n < 2) n = 2;
		lo = 0;
		cnt = n;
		while (cnt > 0) begin
			h = cnt / 2;
			m = lo + h;
			if (model_dist[m] < q) begin
				lo = m + 1;
				cnt = cnt - h - 1;
			end else begin
				cnt = h;
			end
		end
		r.beyond = 1'b0;
		if (lo >= n) begin
			r.level = '0;
			r.beyond = 1'b1;
		end else if (lo == 0) begin
			r.level = model_level[0];
		end else begin
			d0 = model_dist[lo - 1];
			d1 = model_dist[lo];
			num = longint'(q) - d0;
			den = d1 - d0;
			v0 = model_level[lo - 1];
			v1 = model_level[lo];
			if (num <= 0) f = 0;
			else if (num >= den) f = 65536;
			else f = (num << 16) / den;
			r.level = 16'(((65536 - f) * v0 + f * v1 + 32768) >> 16);
		end
		return r;
	endfunction

	// Appends one expected result to the scoreboard.
	function automatic void expect_lookup(lookup_t r);
		pending_lookups.insert(pending_lookups.size(), r);
	endfunction

	// Offers one item and waits for its transfer; updates the model on acceptance.
	// tvalid stays high afterwards so items can follow back to back.
	task automatic send_item(mode_t mode, logic [7:0] slot, logic [31:0] bp_dist,
			logic [15:0] lvl, logic [31:0] q, bit typed, lookup_t typed_r);
		lookup_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= {q, lvl, bp_dist, slot};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (mode == MODE_LOAD) begin
			model_dist[slot] = bp_dist;
			model_level[slot] = lvl;
			load_count++;
		end else begin
			r = predict_lookup(q);
			if (typed && r != typed_r) begin
				$error("directed row disagrees with predictor: level %0h/%0h beyond %0b/%0b",
					typed_r.level, r.level, typed_r.beyond, r.beyond);
				fail_count++;
			end
			expect_lookup(typed ? typed_r : r);
			query_count++;
		end
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_lookups.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// APB write: setup cycle, then the access cycle.
	task automatic write_reg(logic [0:0] addr, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (addr == REG_POINTS_IN_USE) model_points = value[8:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Writes an ascending table over every slot; small steps keep some queries
	// between breakpoints, and repeated distances give zero-width segments.
	task automatic load_ascending_table(int unsigned step_max);
		logic [31:0] d;
		d = $urandom_range(1000);
		for (int i = 0; i < DEPTH; i++) begin
			send_item(MODE_LOAD, 8'(i), d, 16'($urandom), '0, 0, '0);
			d += ($urandom_range(9) == 0) ? 0 : $urandom_range(step_max);
		end
	endtask

	// A query aimed near a breakpoint in use, or anywhere at all.
	function automatic logic [31:0] pick_query();
		int unsigned n, k;
		n = (model_points > DEPTH) ? DEPTH : ((model_points < 2) ? 2 : model_points);
		k = $urandom_range(n - 1);
		case ($urandom_range(5))
			0: return $urandom;
			1: return model_dist[k];
			2: return model_dist[n - 1] + $urandom_range(3);
			default: return model_dist[k] - $urandom_range(2000);
		endcase
	endfunction

	// Output side: random stalls, plus a long hold while recv_hold is set.
	initial begin
		lookup_t got, want;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata, m_axis_tuser};
				result_count++;
				if (pending_lookups.size() == 0) begin
					$error("result with no query waiting: level %0h beyond %0b",
						got.level, got.beyond);
					fail_count++;
				end else begin
					want = pending_lookups.pop_front();
					if (got.level !== want.level) begin
						$error("level_out expected %0h actual %0h", want.level, got.level);
						fail_count++;
					end
					if (got.beyond !== want.beyond) begin
						$error("beyond_table expected %0b actual %0b", want.beyond, got.beyond);
						fail_count++;
					end
				end
			end
		end
	end

	// Watchdog: counts cycles with no transfer on either stream.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	row_t rows [$];

	initial begin
		lookup_t typed_r;
		int unsigned phase_items;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = MODE_LOAD;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		recv_hold = 1'b0;
		fail_count = 0;
		query_count = 0;
		load_count = 0;
		result_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		model_points = 9'd256;
		for (int i = 0; i < DEPTH; i++) begin
			model_dist[i] = '0;
			model_level[i] = '0;
		end
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, on a two-point table: first level at or before the first
		// breakpoint, zero past the last, exact endpoints and a midpoint between.
		write_reg(REG_POINTS_IN_USE, 32'd2);
		rows = '{
			'{MODE_LOAD, 8'd0, 32'h0001_0000, 16'h1000, '0, 0, '0, 0},
			'{MODE_LOAD, 8'd1, 32'h0003_0000, 16'hFFFF, '0, 0, '0, 0},
			'{MODE_QUERY, 8'hFF, '1, '1, 32'h0000_0000, 1, 16'h1000, 0},
			'{MODE_QUERY, '0, '0, '0, 32'h0001_0000, 1, 16'h1000, 0},
			'{MODE_QUERY, '0, '0, '0, 32'h0003_0000, 1, 16'hFFFF, 0},
			'{MODE_QUERY, '0, '0, '0, 32'h0003_0001, 1, 16'h0000, 1},
			'{MODE_QUERY, '0, '0, '0, 32'hFFFF_FFFF, 1, 16'h0000, 1},
			'{MODE_QUERY, '0, '0, '0, 32'h0002_0000, 0, '0, 0},
			'{MODE_QUERY, '0, '0, '0, 32'h0001_0001, 0, '0, 0},
			'{MODE_LOAD, 8'd1, 32'h0001_0000, 16'h0000, '0, 0, '0, 0},
			'{MODE_QUERY, '0, '0, '0, 32'h0001_0000, 1, 16'h1000, 0},
			'{MODE_QUERY, '0, '0, '0, 32'h0001_0001, 1, 16'h0000, 1},
			'{MODE_LOAD, 8'd0, 32'h0000_0000, 16'h0000, '0, 0, '0, 0},
			'{MODE_LOAD, 8'd1, 32'hFFFF_FFFF, 16'hFFFF, '0, 0, '0, 0},
			'{MODE_QUERY, '0, '0, '0, 32'h8000_0000, 0, '0, 0},
			'{MODE_QUERY, '0, '0, '0, 32'hFFFF_FFFE, 0, '0, 0},
			'{MODE_QUERY, '0, '0, '0, 32'h0000_0001, 0, '0, 0},
			// A descending pair still gives a clamped, well-defined result.
			'{MODE_LOAD, 8'd1, 32'h0000_0000, 16'h8000, '0, 0, '0, 0},
			'{MODE_LOAD, 8'd0, 32'h0005_0000, 16'h4000, '0, 0, '0, 0},
			'{MODE_QUERY, '0, '0, '0, 32'h0000_0000, 0, '0, 0},
			'{MODE_QUERY, '0, '0, '0, 32'h0006_0000, 0, '0, 0}
		};
		foreach (rows[i]) begin
			typed_r = {rows[i].want_level, rows[i].want_beyond};
			send_item(rows[i].mode, rows[i].slot, rows[i].bp_dist, rows[i].lvl,
				rows[i].query, rows[i].check_now, typed_r);
		end
		wait_drained();

		// Full table, then random phases over several counts, extremes included.
		// Each phase loads a fresh table so every entry read has been written;
		// random loads later break the order, which the block must still handle.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 33 : ((phase == 1) ? 53 : 0);
			recv_idle_pct = (phase == 0) ? 53 : ((phase == 1) ? 33 : 0);
			load_ascending_table((phase == 1) ? 32'hFFFF : 32'h00FF_FFFF);
			for (int sub = 0; sub < 3; sub++) begin
				wait_drained();
				case (sub)
					0: write_reg(REG_POINTS_IN_USE, (phase == 0) ? 32'd256 : 32'd2);
					1: write_reg(REG_POINTS_IN_USE, 32'($urandom_range(3, 255)));
					default: write_reg(REG_POINTS_IN_USE, (phase == 2) ? 32'd511 : 32'd0);
				endcase
				phase_items = RANDOM_ITEMS / 9;
				for (int k = 0; k < phase_items; k++) begin
					if (phase == 2 && sub == 0 && k == 10) begin
						// Hold off long enough for the queue to fill, then release.
						recv_hold = 1'b1;
						fork
							begin
								repeat (300) @(negedge clk);
								recv_hold = 1'b0;
							end
						join_none
					end
					if ($urandom_range(19) == 0)
						send_item(MODE_LOAD, 8'($urandom), 32'($urandom), 16'($urandom),
							32'($urandom), 0, '0);
					else
						send_item(MODE_QUERY, 8'($urandom), 32'($urandom), 16'($urandom),
							pick_query(), 0, '0);
				end
			end
			wait_drained();
		end

		// Set the register back to 256 before the final drain.
		write_reg(REG_POINTS_IN_USE, 32'd256);
		wait_drained();
		$display("Covered %0d loads and %0d queries, %0d results checked,",
			load_count, query_count, result_count);
		$display("table counts from two to full, in-range and saturating register values.");
		if (fail_count == 0 && pending_lookups.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

[profile_interpolation_lookup_unit.f]
rtl/core/pil_pkg.sv
rtl/core/pil_front.sv
rtl/core/pil_engine.sv
rtl/core/profile_interpolation_lookup_unit.sv
bench/tb.sv
